// File: sv/rau_pkg.sv
package rau_pkg;

	localparam int OpW = 32;
	localparam int MagW = 2 * OpW;
	localparam int MagCntW = $clog2(MagW + 1);

	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_EQ  = 3'd4,
		OP_INC = 3'd5,
		OP_DEC = 3'd6,
		OP_NOP = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_ZERO = 2'd1,
		ST_OVF  = 2'd2
	} status_t;

	// Sequencer states of the top level.
	typedef enum logic [3:0] {
		S_IDLE, S_MUL, S_SUM, S_CHK, S_GCD, S_GWAIT, S_DN, S_DNW, S_DD, S_DDW,
		S_FIN, S_OUT
	} state_t;

	// Requests to the shared divider: quotient and remainder of a / b.
	typedef struct packed {
		logic            start;
		logic [MagW-1:0] dividend;
		logic [MagW-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic            done;
		logic            busy;
		logic [MagW-1:0] quot;
		logic [MagW-1:0] rem;
	} div_rsp_t;

endpackage

// File: sv/rau_div.sv
module rau_div (
	input  logic                clk,
	input  logic                arst_n,
	input  rau_pkg::div_req_t   req,
	output rau_pkg::div_rsp_t   rsp
);

	logic [rau_pkg::MagW-1:0]    quot_q;
	logic [rau_pkg::MagW-1:0]    rem_q;
	logic [rau_pkg::MagW-1:0]    dvs_q;
	logic [rau_pkg::MagCntW-1:0] cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic [rau_pkg::MagW:0]      trial;
	logic [rau_pkg::MagW:0]      diff;

	// One quotient bit per cycle, restoring.
	always_comb begin
		trial = {rem_q, quot_q[rau_pkg::MagW-1]};
		diff  = trial - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= rau_pkg::MagCntW'(rau_pkg::MagW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == rau_pkg::MagCntW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quot_q <= req.dividend;
			rem_q  <= '0;
			dvs_q  <= req.divisor;
		end else if (busy_q) begin
			if (!diff[rau_pkg::MagW]) begin
				rem_q <= diff[rau_pkg::MagW-1:0];
				quot_q <= {quot_q[rau_pkg::MagW-2:0], 1'b1};
			end else begin
				rem_q <= trial[rau_pkg::MagW-1:0];
				quot_q <= {quot_q[rau_pkg::MagW-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.busy = busy_q;
	assign rsp.quot = quot_q;
	assign rsp.rem  = rem_q;

endmodule

// File: sv/rational_arithmetic_unit.sv
// Channel | Dir | Payload
// s_axis  | in  | tdata: operation[2:0], a_num, a_den, b_num, b_den (136 bits)
// m_axis  | out | tdata: res_num, res_den, equal, status (66 bits -> 72)
//
// A beat is accepted in IDLE, forms its four products in MUL (one shared multiplier, one
// product per cycle) and is set up in SUM and CHK. Each Euclidean step is one run of the
// shared 64-step divider; a 64-bit gcd needs up to about ninety steps, and two more runs
// divide numerator and denominator by the gcd. The equal test reduces both fractions in
// turn. Zero denominators and the unused code skip the divider and go straight to the
// output. Reset clears the sequencer; the block takes no new beat until its result has
// been taken from the output register.
module rational_arithmetic_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [135:0] s_axis_tdata,  // operation, a_num, a_den, b_num, b_den
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [71:0]  m_axis_tdata   // res_num, res_den, equal, status, zero pad
);

	localparam int W = rau_pkg::OpW;
	localparam int MW = rau_pkg::MagW;

	rau_pkg::state_t state_q, state_d;

	logic [2:0]          op_q;
	logic [W-1:0]        an_q, ad_q, bn_q, bd_q;
	logic [1:0]          mcnt_q;
	logic [MW-1:0]       p_q [4];
	logic                pn_q [4];
	logic [MW-1:0]       nmag_q, dmag_q, x_q, y_q, g_q, rn_q, rd_q;
	logic                nneg_q, second_q;
	// first reduced fraction for equal test
	logic [MW-1:0]       en_q, ed_q;
	logic                eneg_q;
	logic [W-1:0]        rnum_q;
	logic [W-2:0]        rden_q;
	logic                req_q;
	logic [1:0]          st_q;

	rau_pkg::div_req_t   dreq;
	rau_pkg::div_rsp_t   drsp;
	logic                dstart;
	logic [MW-1:0]       ddvd, ddvs;

	function automatic logic [W:0] smag(input logic [W-1:0] v);
		logic neg;
		logic [W-1:0] m;
		neg = v[W-1];
		m = neg ? (~v + 1'b1) : v;
		return {neg, m};
	endfunction

	logic [W:0] sa_n, sa_d, sb_n, sb_d;
	assign sa_n = smag(an_q);
	assign sa_d = smag(ad_q);
	assign sb_n = smag(bn_q);
	assign sb_d = smag(bd_q);

	// single shared multiplier: product index mcnt_q
	logic [W:0] mx, my;
	always_comb begin
		case (mcnt_q)
			2'd0: begin mx = sa_n; my = sb_d; end
			2'd1: begin mx = sb_n; my = sa_d; end
			2'd2: begin mx = sa_n; my = sb_n; end
			default: begin mx = sa_d; my = sb_d; end
		endcase
	end

	// signed-magnitude add of two products, or of a_num and a_den for inc/dec
	logic [MW-1:0] sum_mag;
	logic          sum_neg;
	always_comb begin
		logic [MW-1:0] xm, ym;
		logic xn, yn;
		xm = p_q[0]; xn = pn_q[0];
		ym = p_q[1]; yn = pn_q[1];
		if (op_q == rau_pkg::OP_INC || op_q == rau_pkg::OP_DEC) begin
			xm = MW'(sa_n[W-1:0]); xn = sa_n[W];
			ym = MW'(sa_d[W-1:0]); yn = sa_d[W] && (sa_d[W-1:0] != '0);
		end
		if ((op_q == rau_pkg::OP_SUB || op_q == rau_pkg::OP_DEC) && ym != '0)
			yn = ~yn;
		if (xn == yn) begin
			sum_mag = xm + ym; sum_neg = xn;
		end else if (xm >= ym) begin
			sum_mag = xm - ym; sum_neg = xn;
		end else begin
			sum_mag = ym - xm; sum_neg = yn;
		end
		if (sum_mag == '0) sum_neg = 1'b0;
	end

	assign dreq.start    = dstart;
	assign dreq.dividend = ddvd;
	assign dreq.divisor  = ddvs;

	rau_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= rau_pkg::S_IDLE;
		else state_q <= state_d;
	end

	logic [MW-1:0] lim;
	assign lim = MW'({(W-1){1'b1}});

	always_comb begin
		state_d = state_q;
		dstart = 1'b0;
		ddvd = x_q;
		ddvs = y_q;
		unique case (state_q)
			rau_pkg::S_IDLE: if (s_axis_tvalid) state_d = rau_pkg::S_MUL;
			rau_pkg::S_MUL: if (mcnt_q == 2'd3) state_d = rau_pkg::S_SUM;
			rau_pkg::S_SUM: state_d = rau_pkg::S_CHK;
			rau_pkg::S_CHK: state_d = rau_pkg::S_GCD;
			rau_pkg::S_GCD: begin
				if (y_q == '0) state_d = rau_pkg::S_DN;
				else begin dstart = 1'b1; state_d = rau_pkg::S_GWAIT; end
			end
			rau_pkg::S_GWAIT: if (drsp.done) state_d = rau_pkg::S_GCD;
			rau_pkg::S_DN: begin
				dstart = 1'b1; ddvd = nmag_q; ddvs = g_q; state_d = rau_pkg::S_DNW;
			end
			rau_pkg::S_DNW: if (drsp.done) state_d = rau_pkg::S_DD;
			rau_pkg::S_DD: begin
				dstart = 1'b1; ddvd = dmag_q; ddvs = g_q; state_d = rau_pkg::S_DDW;
			end
			rau_pkg::S_DDW: if (drsp.done) state_d = rau_pkg::S_FIN;
			rau_pkg::S_FIN: state_d = (op_q == rau_pkg::OP_EQ && !second_q) ?
				rau_pkg::S_CHK : rau_pkg::S_OUT;
			rau_pkg::S_OUT: if (m_axis_tready) state_d = rau_pkg::S_IDLE;
			default: state_d = rau_pkg::S_IDLE;
		endcase
		// early exits go straight to the output
		if (state_q == rau_pkg::S_SUM && req_q) state_d = rau_pkg::S_OUT;
	end

	assign s_axis_tready = (state_q == rau_pkg::S_IDLE);
	assign m_axis_tvalid = (state_q == rau_pkg::S_OUT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mcnt_q <= '0;
			second_q <= 1'b0;
			req_q <= 1'b0;
			st_q <= rau_pkg::ST_OK;
		end else begin
			unique case (state_q)
				rau_pkg::S_IDLE: begin
					mcnt_q <= '0;
					second_q <= 1'b0;
					req_q <= 1'b0;
					st_q <= rau_pkg::ST_OK;
				end
				rau_pkg::S_MUL: begin
					mcnt_q <= mcnt_q + 1'b1;
					if (mcnt_q == 2'd3) begin
						// decide early exits
						if (op_q == rau_pkg::OP_NOP) req_q <= 1'b1;
						else if (op_q == rau_pkg::OP_EQ) begin
							if (sa_d[W-1:0] == '0 || sb_d[W-1:0] == '0) begin
								req_q <= 1'b1; st_q <= rau_pkg::ST_ZERO;
							end
						end else if (op_q == rau_pkg::OP_INC || op_q == rau_pkg::OP_DEC) begin
							if (sa_d[W-1:0] == '0) begin
								req_q <= 1'b1; st_q <= rau_pkg::ST_ZERO;
							end
						end else if (op_q == rau_pkg::OP_DIV) begin
							if (sb_n[W-1:0] == '0 || sa_d[W-1:0] == '0) begin
								req_q <= 1'b1; st_q <= rau_pkg::ST_ZERO;
							end
						end else if (sa_d[W-1:0] == '0 || sb_d[W-1:0] == '0) begin
							req_q <= 1'b1; st_q <= rau_pkg::ST_ZERO;
						end
					end
				end
				rau_pkg::S_FIN: second_q <= 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			rau_pkg::S_IDLE: begin
				op_q <= s_axis_tdata[2:0];
				an_q <= s_axis_tdata[34:3];
				ad_q <= s_axis_tdata[66:35];
				bn_q <= s_axis_tdata[98:67];
				bd_q <= s_axis_tdata[130:99];
				rnum_q <= '0;
				rden_q <= '0;
			end
			rau_pkg::S_MUL: begin
				p_q[mcnt_q] <= MW'(mx[W-1:0]) * MW'(my[W-1:0]);
				pn_q[mcnt_q] <= mx[W] ^ my[W];
			end
			rau_pkg::S_SUM: begin
				if (op_q == rau_pkg::OP_NOP) rden_q <= (W-1)'(1);
				// The numerator magnitude comes from the first decode, the denominator
				// magnitude and the sign of the whole fraction from the second.
				unique case (op_q)
					rau_pkg::OP_ADD, rau_pkg::OP_SUB, rau_pkg::OP_INC, rau_pkg::OP_DEC: begin
						nmag_q <= sum_mag;
					end
					rau_pkg::OP_MUL: nmag_q <= p_q[2];
					rau_pkg::OP_DIV: nmag_q <= p_q[0];
					default: nmag_q <= MW'(sa_n[W-1:0]);
				endcase
				unique case (op_q)
					rau_pkg::OP_INC, rau_pkg::OP_DEC, rau_pkg::OP_EQ, rau_pkg::OP_NOP: begin
						dmag_q <= MW'(sa_d[W-1:0]); nneg_q <= (op_q == rau_pkg::OP_EQ) ?
							(sa_n[W] ^ sa_d[W]) : (sum_neg ^ sa_d[W]);
					end
					rau_pkg::OP_DIV: begin dmag_q <= p_q[1]; nneg_q <= pn_q[0] ^ pn_q[1]; end
					default: begin
						dmag_q <= p_q[3];
						nneg_q <= ((op_q == rau_pkg::OP_MUL) ? pn_q[2] : sum_neg) ^ pn_q[3];
					end
				endcase
			end
			rau_pkg::S_CHK: begin
				if (second_q) begin
					nmag_q <= MW'(sb_n[W-1:0]); dmag_q <= MW'(sb_d[W-1:0]);
					nneg_q <= sb_n[W] ^ sb_d[W];
					x_q <= MW'(sb_n[W-1:0]); y_q <= MW'(sb_d[W-1:0]);
				end else begin
					x_q <= nmag_q; y_q <= dmag_q;
				end
			end
			rau_pkg::S_GCD: if (y_q == '0) g_q <= x_q;
			rau_pkg::S_GWAIT: if (drsp.done) begin x_q <= y_q; y_q <= drsp.rem; end
			rau_pkg::S_DNW: if (drsp.done) rn_q <= drsp.quot;
			rau_pkg::S_DDW: if (drsp.done) rd_q <= drsp.quot;
			rau_pkg::S_FIN: begin
				if (op_q == rau_pkg::OP_EQ) begin
					if (!second_q) begin
						en_q <= rn_q; ed_q <= (rn_q == '0) ? MW'(1) : rd_q;
						eneg_q <= nneg_q && (rn_q != '0);
					end
				end else if (rn_q == '0) begin
					rnum_q <= '0; rden_q <= (W-1)'(1);
				end else if (rd_q > lim || rn_q > (nneg_q ? lim + 1'b1 : lim)) begin
					rnum_q <= '0; rden_q <= '0;
				end else begin
					rnum_q <= nneg_q ? (~rn_q[W-1:0] + 1'b1) : rn_q[W-1:0];
					rden_q <= rd_q[W-2:0];
				end
			end
			default: ;
		endcase
	end

	// status and equal settle in FIN; computed from registered values
	logic eq_flag, ovf_flag;
	always_comb begin
		logic [MW-1:0] d2;
		logic n2;
		d2 = (rn_q == '0) ? MW'(1) : rd_q;
		n2 = nneg_q && (rn_q != '0);
		eq_flag = (op_q == rau_pkg::OP_EQ) && !req_q &&
			en_q == rn_q && ed_q == d2 && eneg_q == n2;
		ovf_flag = (op_q != rau_pkg::OP_EQ) && (op_q != rau_pkg::OP_NOP) && !req_q &&
			(rn_q != '0) && (rd_q > lim || rn_q > (nneg_q ? lim + 1'b1 : lim));
	end

	logic [1:0] st_out;
	assign st_out = ovf_flag ? rau_pkg::ST_OVF : st_q;

	assign m_axis_tdata = {6'd0, st_out, eq_flag, rden_q, rnum_q};

	a_one_beat: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid)) else $error("in and out both open");
	a_ovf_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && st_out != rau_pkg::ST_OK) |-> (m_axis_tdata[62:0] == '0))
		else $error("flagged result carries data");
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rau_pkg::S_OUT) |-> !drsp.busy) else $error("divider busy at output");

endmodule

// File: test/rau_checker.sv
module rau_checker
	import rau_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [135:0] s_axis_tdata,  // operation, a_num, a_den, b_num, b_den
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [71:0]  m_axis_tdata,  // res_num, res_den, equal, status, zero pad
	output int           mismatches,
	output int           pending
);

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		bit              neg;
		longint unsigned mag;
	} signmag_t;

	typedef struct {
		logic [31:0] num;
		logic [30:0] den;
		logic        eq;
		status_t     st;
	} fraction_t;

	fraction_t expected_results[$];

	function automatic signmag_t to_signmag(input logic [31:0] v);
		signmag_t r;
		r.neg = v[31];
		r.mag = r.neg ? (64'h1_0000_0000 - {32'd0, v}) : {32'd0, v};
		return r;
	endfunction

	function automatic signmag_t sm_product(input signmag_t x, input signmag_t y);
		signmag_t r;
		r.mag = x.mag * y.mag;
		r.neg = (r.mag != 0) && (x.neg != y.neg);
		return r;
	endfunction

	function automatic signmag_t sm_sum(input signmag_t x, input signmag_t y);
		signmag_t r;
		if (x.neg == y.neg) begin
			r.mag = x.mag + y.mag;
			r.neg = x.neg;
		end else if (x.mag >= y.mag) begin
			r.mag = x.mag - y.mag;
			r.neg = x.neg;
		end else begin
			r.mag = y.mag - x.mag;
			r.neg = y.neg;
		end
		if (r.mag == 0)
			r.neg = 1'b0;
		return r;
	endfunction

	function automatic signmag_t sm_neg(input signmag_t x);
		signmag_t r;
		r = x;
		if (x.mag != 0)
			r.neg = !x.neg;
		return r;
	endfunction

	// Reduces n/d by the gcd of the magnitudes; d must be nonzero.
	function automatic void lowest_terms(input signmag_t n, input signmag_t d,
			output signmag_t rn, output longint unsigned rd);
		longint unsigned x, y, t;
		x = n.mag;
		y = d.mag;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		rn.mag = n.mag / x;
		rn.neg = (rn.mag != 0) && (n.neg != d.neg);
		rd = d.mag / x;
		if (rn.mag == 0)
			rd = 1;
	endfunction

	function automatic fraction_t rational_result(input logic [135:0] beat);
		fraction_t r;
		op_t op;
		signmag_t an, ad, bn, bd, n, d, rn, xn, yn;
		longint unsigned rd, xd, yd, lim;
		op = op_t'(beat[2:0]);
		an = to_signmag(beat[34:3]);
		ad = to_signmag(beat[66:35]);
		bn = to_signmag(beat[98:67]);
		bd = to_signmag(beat[130:99]);
		lim = 64'h7FFF_FFFF;
		r.num = '0;
		r.den = '0;
		r.eq = 1'b0;
		r.st = ST_OK;
		if (op == OP_NOP) begin
			r.den = 31'd1;
			return r;
		end
		if (op == OP_EQ) begin
			if (ad.mag == 0 || bd.mag == 0) begin
				r.st = ST_ZERO;
				return r;
			end
			lowest_terms(an, ad, xn, xd);
			lowest_terms(bn, bd, yn, yd);
			r.eq = (xn.neg == yn.neg) && (xn.mag == yn.mag) && (xd == yd);
			return r;
		end
		case (op)
			OP_ADD: begin
				n = sm_sum(sm_product(an, bd), sm_product(bn, ad));
				d = sm_product(ad, bd);
			end
			OP_SUB: begin
				n = sm_sum(sm_product(an, bd), sm_neg(sm_product(bn, ad)));
				d = sm_product(ad, bd);
			end
			OP_MUL: begin
				n = sm_product(an, bn);
				d = sm_product(ad, bd);
			end
			OP_DIV: begin
				n = sm_product(an, bd);
				d = sm_product(bn, ad);
			end
			OP_INC: begin
				n = sm_sum(an, ad);
				d = ad;
			end
			default: begin
				n = sm_sum(an, sm_neg(ad));
				d = ad;
			end
		endcase
		if (d.mag == 0) begin
			r.st = ST_ZERO;
			return r;
		end
		lowest_terms(n, d, rn, rd);
		if (rd > lim || rn.mag > (rn.neg ? lim + 1 : lim)) begin
			r.st = ST_OVF;
			return r;
		end
		r.num = rn.neg ? (32'd0 - rn.mag[31:0]) : rn.mag[31:0];
		r.den = rd[30:0];
		return r;
	endfunction

	assign pending = expected_results.size();

	always @(posedge clk or negedge arst_n) begin
		fraction_t want;
		logic [31:0] got_num;
		logic [30:0] got_den;
		logic got_eq;
		logic [1:0] got_st;
		if (!arst_n) begin
			mismatches <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				expected_results.push_back(rational_result(s_axis_tdata));
			if (m_axis_tvalid && m_axis_tready) begin
				got_num = m_axis_tdata[31:0];
				got_den = m_axis_tdata[62:32];
				got_eq = m_axis_tdata[63];
				got_st = m_axis_tdata[65:64];
				if (expected_results.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected result beat %h", m_axis_tdata);
					mismatches <= mismatches + 1;
				end else begin
					want = expected_results.pop_front();
					if (got_num !== want.num || got_den !== want.den ||
							got_eq !== want.eq || got_st !== want.st) begin
						if (mismatches < 10)
							$display("mismatch: expected num %h den %h eq %b st %0d, got num %h den %h eq %b st %0d",
								want.num, want.den, want.eq, want.st,
								got_num, got_den, got_eq, got_st);
						mismatches <= mismatches + 1;
					end
				end
			end
		end
	end

endmodule

// File: test/tb_rational_arithmetic_unit.sv
module tb_rational_arithmetic_unit;

	timeunit 1ns;
	timeprecision 1ps;

	import rau_pkg::*;

	// A random beat can need about a hundred divider runs, so the ceiling
	// assumes every beat is that slow, adds the longest gaps and stalls,
	// and leaves a wide margin.
	localparam longint CycleLimit = 64'd45_000_000;
	localparam int RandomBeats = 1800;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [135:0] s_axis_tdata = '0;  // operation, a_num, a_den, b_num, b_den
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [71:0]  m_axis_tdata;       // res_num, res_den, equal, status, zero pad

	int mismatches;
	int pending;
	longint cycles = 0;
	bit hold_off = 1'b0;
	int sent = 0;

	always #2 clk = ~clk;

	rational_arithmetic_unit uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	rau_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.mismatches    (mismatches),
		.pending       (pending)
	);

	// The watchdog ends a run that hangs.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// A quarter of the gaps are empty; most others come from the short range, now and then from the long one.
	function automatic int gap_len();
		if ($urandom_range(0, 3) == 0)
			return 0;
		return ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(10, 60);
	endfunction

	// The receiver drops tready at random. Once, while hold_off is set, it
	// refuses results so that the output register fills and the input side
	// stalls against a waiting sender.
	initial begin
		int run;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				m_axis_tready <= 1'b0;
				repeat (3000) @(negedge clk);
				hold_off = 1'b0;
			end
			run = gap_len();
			if (run > 0) begin
				m_axis_tready <= 1'b0;
				repeat (run) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
	end

	// Offers one beat after a random gap and returns at the falling edge
	// after it was taken. tvalid is lowered only when a gap follows, so a
	// back-to-back beat never sees it fall and rise in the same step.
	task automatic offer_beat(input op_t op, input logic [31:0] an, input logic [31:0] ad,
			input logic [31:0] bn, input logic [31:0] bd);
		int run;
		run = gap_len();
		if (run > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (run) @(negedge clk);
		end
		s_axis_tdata <= {5'd0, bd, bn, ad, an, op};
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		@(negedge clk);
		sent++;
	endtask

	// Operand values: edge values, small values that often cancel or give
	// zero denominators, mid-size values and fully random words.
	function automatic logic [31:0] operand();
		case ($urandom_range(0, 9))
			0: case ($urandom_range(0, 4))
				0: return 32'h8000_0000;
				1: return 32'h7FFF_FFFF;
				2: return 32'hFFFF_FFFF;
				3: return 32'd1;
				default: return 32'd0;
			endcase
			1, 2, 3: return $urandom_range(0, 40) - 20;
			4, 5: return $urandom_range(0, 200000) - 100000;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		op_t op;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed beats: every operation, the zero denominator cases, the
		// overflow cases, a zero result and the unused operation code.
		offer_beat(OP_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
		offer_beat(OP_SUB, 32'd1, 32'd2, 32'd1, 32'd2);
		offer_beat(OP_MUL, -32'sd3, 32'd4, 32'd8, -32'sd9);
		offer_beat(OP_DIV, 32'd6, 32'd7, -32'sd2, 32'd5);
		offer_beat(OP_DIV, 32'd6, 32'd7, 32'd0, 32'd5);
		offer_beat(OP_EQ, 32'd2, 32'd4, -32'sd1, -32'sd2);
		offer_beat(OP_EQ, 32'd2, 32'd4, 32'd1, -32'sd2);
		offer_beat(OP_EQ, 32'd2, 32'd0, 32'd1, 32'd2);
		offer_beat(OP_INC, 32'd5, -32'sd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		offer_beat(OP_DEC, 32'd5, 32'd3, 32'h8000_0000, 32'h0);
		offer_beat(OP_ADD, 32'd1, 32'd0, 32'd1, 32'd1);
		offer_beat(OP_INC, 32'h7FFF_FFFF, 32'd1, 32'd0, 32'd0);
		offer_beat(OP_DEC, 32'h8000_0000, 32'd1, 32'd0, 32'd0);
		offer_beat(OP_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
		offer_beat(OP_MUL, 32'h8000_0000, 32'd1, 32'h8000_0000, 32'd1);
		offer_beat(OP_DIV, 32'h8000_0000, 32'd1, -32'sd1, 32'd1);
		offer_beat(OP_DIV, 32'd1, 32'h8000_0000, 32'd1, 32'd1);
		offer_beat(OP_SUB, 32'h7FFF_FFFF, 32'h7FFF_FFFE, 32'h7FFF_FFFE, 32'h7FFF_FFFD);
		offer_beat(OP_ADD, 32'd0, -32'sd7, 32'd0, 32'd3);
		offer_beat(OP_EQ, 32'h8000_0000, 32'h8000_0000, 32'd1, 32'd1);
		offer_beat(OP_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

		for (int i = 0; i < RandomBeats; i++) begin
			// The long receiver stall starts early, while beats keep coming.
			if (i == 40)
				hold_off = 1'b1;
			op = op_t'($urandom_range(0, 7));
			offer_beat(op, operand(), operand(), operand(), operand());
		end
		s_axis_tvalid <= 1'b0;

		// Drain, then give a late extra beat time to show up.
		while (pending != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);

		if (mismatches == 0 && pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// File: files.f
sv/rau_pkg.sv
sv/rau_div.sv
sv/rational_arithmetic_unit.sv
test/rau_checker.sv
test/tb_rational_arithmetic_unit.sv
